>>> rtl/gaussian_2d_pixel_eval_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian pixel evaluator
// Two property forms, same cycle and next cycle, that compile away when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_2D_PIXEL_EVAL_CORE_MACROS_SVH
`define GAUSSIAN_2D_PIXEL_EVAL_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define G2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gaussian evaluator check failed");
`define G2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gaussian evaluator check failed");
`else
`define G2D_ASSERT_NOW(label, ante, cons)
`define G2D_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/g2d_pkg.sv
// ----------------------------------------------------------------------------
// g2d_pkg
// Types, register indexes and fixed-point constants of the Gaussian pixel
// evaluator.
// ----------------------------------------------------------------------------
package g2d_pkg;

    localparam int unsigned GRID_DIM   = 1024;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_SIGMA_ROW    = 3'd2,
        CFG_SIGMA_COL    = 3'd3,
        CFG_PEAK_HEIGHT  = 3'd4,
        CFG_OFFSET_LEVEL = 3'd5,
        CFG_NUM_ROWS     = 3'd6,
        CFG_NUM_COLS     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pixel_value;
        logic               last_pixel;
        logic               outside_grid;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic last_pixel;
        logic outside_grid;
    } t_side;

    // Exponent context that travels along the series evaluation.
    typedef struct packed {
        logic [29:0] y;
        logic [4:0]  k;
        logic        kbig;
    } t_hctx;

    typedef enum logic [1:0] {
        HD_IDLE,
        HD_MUL,
        HD_DIV,
        HD_DONE
    } t_hdiv_state;

    localparam logic [30:0] LOG2E_Q30        = 31'd1549082005;
    localparam logic [29:0] LN2_Q30          = 30'd744261118;
    localparam logic [30:0] ONE_Q30          = 31'd1073741824;
    localparam logic [30:0] INV_SQRT_2PI_Q32 = 31'd1713444562;
    localparam logic [22:0] U_CLAMP          = 23'd4194304;
    // Default normalization for both widths at 1.0.
    localparam logic [31:0] H_DFLT_RESET     = 32'd26145;

    // floor(2^32 / n) for the series divisors n = 1 .. 9.
    localparam logic [32:0] HORNER_RECIP [1:9] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765,
        33'd1073741824, 33'd858993459,  33'd715827882,
        33'd613566756,  33'd536870912,  33'd477218588
    };

endpackage

>>> rtl/gaussian_2d_pixel_eval_core.sv
// ----------------------------------------------------------------------------
// gaussian_2d_pixel_eval_core
// Evaluates an axis-aligned 2D Gaussian plus background at one grid pixel per
// word, in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// The core accepts one (row, col) word per clock and returns one result word
// per clock while neither the input nor the output side is stalled. Each
// word passes through the pipeline in order: two stages of setup, a 24-stage
// restoring divider per axis that scales the centre distance by sigma, five
// stages for the clamp, squaring and the change to base two, nine series
// steps of three stages each for the fractional power of two, and two stages
// for the final shift and the amplitude multiply, followed by the output
// register. A stall at the output while a word is presented freezes the
// whole pipeline; nothing is dropped or repeated.
// When peak_height is zero the amplitude is the default normalization, which
// a serial divider recomputes after every write of sigma_row or sigma_col:
// while it runs the input side is stalled. There is no clearing pass after
// reset; the default amplitude for the reset widths is loaded directly.
// Configuration registers are written through a plain write port and must
// only be written while no word is in flight.
`include "gaussian_2d_pixel_eval_core_macros.svh"

module gaussian_2d_pixel_eval_core
    import g2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  logic                  i_out_stall
);

    localparam int unsigned DIV_STEPS    = 24;
    localparam int unsigned HORNER_STEPS = 9;
    // input, abs, divider, clamp, square, sum, log2e, y, series, shift, gain
    localparam int unsigned LAT = 2 + DIV_STEPS + 5 + 3 * HORNER_STEPS + 2;
    localparam int unsigned HD_ITERS = 47;
    localparam logic [5:0]  HD_LAST  = 6'(HD_ITERS - 1);
    localparam logic [16:0] GRID_DIM_W = 17'(GRID_DIM);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [25:0] r_center_x;
    logic [25:0] r_center_y;
    logic [23:0] r_sigma_row;
    logic [23:0] r_sigma_col;
    logic [31:0] r_peak;
    logic [31:0] r_offset;
    logic [10:0] r_num_rows;
    logic [10:0] r_num_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_sigma_row <= 24'd65536;
            r_sigma_col <= 24'd65536;
            r_peak      <= '0;
            r_offset    <= '0;
            r_num_rows  <= 11'd1024;
            r_num_cols  <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:     r_center_x  <= i_cfg_data[25:0];
                CFG_CENTER_Y:     r_center_y  <= i_cfg_data[25:0];
                CFG_SIGMA_ROW:    r_sigma_row <= i_cfg_data[23:0];
                CFG_SIGMA_COL:    r_sigma_col <= i_cfg_data[23:0];
                CFG_PEAK_HEIGHT:  r_peak      <= i_cfg_data;
                CFG_OFFSET_LEVEL: r_offset    <= i_cfg_data;
                CFG_NUM_ROWS:     r_num_rows  <= i_cfg_data[10:0];
                CFG_NUM_COLS:     r_num_cols  <= i_cfg_data[10:0];
            endcase
        end
    end

    // A width of zero behaves as one LSB.
    logic [23:0] sig_eff [2];
    logic [25:0] centre  [2];
    assign sig_eff[0] = (r_sigma_row == '0) ? 24'd1 : r_sigma_row;
    assign sig_eff[1] = (r_sigma_col == '0) ? 24'd1 : r_sigma_col;
    assign centre[0]  = r_center_x;
    assign centre[1]  = r_center_y;

    // ------------------------------------------------------------------
    // Default amplitude: (INV_SQRT_2PI << 16) / (sigma_row * sigma_col),
    // one quotient bit per cycle, restarted by any sigma write.
    // ------------------------------------------------------------------
    t_hdiv_state r_hd_state;
    t_hdiv_state n_hd_state;
    logic [5:0]  r_hd_cnt;
    logic [47:0] r_hd_div;
    logic [47:0] r_hd_rem;
    logic [46:0] r_hd_quo;
    logic [31:0] r_h_dflt;
    logic        sig_wr;
    logic        hd_busy;
    logic        hd_load;
    logic        hd_step;
    logic        hd_done;
    logic [48:0] hd_rem_sh;
    logic [48:0] hd_diff;
    logic        hd_ge;

    assign sig_wr = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_SIGMA_ROW ||
                                 t_cfg_idx'(i_cfg_idx) == CFG_SIGMA_COL);

    always_comb begin
        n_hd_state = r_hd_state;
        if (sig_wr) begin
            n_hd_state = HD_MUL;
        end else begin
            unique case (r_hd_state)
                HD_IDLE: n_hd_state = HD_IDLE;
                HD_MUL:  n_hd_state = HD_DIV;
                HD_DIV: begin
                    if (r_hd_cnt == HD_LAST) begin
                        n_hd_state = HD_DONE;
                    end
                end
                HD_DONE: n_hd_state = HD_IDLE;
            endcase
        end
    end

    always_comb begin
        hd_busy = 1'b1;
        hd_load = 1'b0;
        hd_step = 1'b0;
        hd_done = 1'b0;
        unique case (r_hd_state)
            HD_IDLE: hd_busy = 1'b0;
            HD_MUL:  hd_load = 1'b1;
            HD_DIV:  hd_step = 1'b1;
            HD_DONE: hd_done = 1'b1;
        endcase
    end

    assign hd_rem_sh = {r_hd_rem, r_hd_quo[46]};
    assign hd_diff   = hd_rem_sh - {1'b0, r_hd_div};
    assign hd_ge     = hd_rem_sh >= {1'b0, r_hd_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_state <= HD_IDLE;
            r_hd_cnt   <= '0;
            r_h_dflt   <= H_DFLT_RESET;
        end else begin
            r_hd_state <= n_hd_state;
            if (hd_load) begin
                r_hd_cnt <= '0;
            end else if (hd_step) begin
                r_hd_cnt <= r_hd_cnt + 6'd1;
            end
            if (hd_done) begin
                r_h_dflt <= (|r_hd_quo[46:32]) ? 32'hFFFF_FFFF : r_hd_quo[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hd_load) begin
            r_hd_div <= {24'b0, sig_eff[0]} * {24'b0, sig_eff[1]};
            r_hd_rem <= '0;
            r_hd_quo <= {INV_SQRT_2PI_Q32, 16'b0};
        end else if (hd_step) begin
            r_hd_rem <= hd_ge ? hd_diff[47:0] : hd_rem_sh[47:0];
            r_hd_quo <= {r_hd_quo[45:0], hd_ge};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the output
    // register holds a word that is being stalled.
    // ------------------------------------------------------------------
    logic           pipe_en;
    logic           in_take;
    logic [LAT-1:0] r_vld;
    t_side          r_side [LAT];
    logic           r_out_vld;
    t_out_word      r_out;
    t_side          in_side;
    logic [16:0]    nr_lim;
    logic [16:0]    nc_lim;
    logic [16:0]    row_ext;
    logic [16:0]    col_ext;

    assign pipe_en    = !r_out_vld || !i_out_stall;
    assign o_in_stall = !pipe_en || hd_busy;
    assign in_take    = i_in_valid && !o_in_stall;

    // Grid flags are settled at entry and ride along with the word.
    assign nr_lim  = ({6'b0, r_num_rows} > GRID_DIM_W) ? GRID_DIM_W : {6'b0, r_num_rows};
    assign nc_lim  = ({6'b0, r_num_cols} > GRID_DIM_W) ? GRID_DIM_W : {6'b0, r_num_cols};
    assign row_ext = {7'b0, i_in_word.row};
    assign col_ext = {7'b0, i_in_word.col};
    assign in_side.outside_grid = (row_ext >= nr_lim) || (col_ext >= nc_lim);
    assign in_side.last_pixel   = (nr_lim != '0) && (nc_lim != '0) &&
                                  (row_ext == nr_lim - 17'd1) &&
                                  (col_ext == nc_lim - 17'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_vld     <= {r_vld[LAT-2:0], in_take};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_side[0] <= in_side;
            for (int i = 1; i < LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Entry and distance stages
    // ------------------------------------------------------------------
    logic [9:0]  r_coord [2];
    logic [26:0] r_dist  [2];
    logic [27:0] diff    [2];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_coord[0] <= i_in_word.row;
            r_coord[1] <= i_in_word.col;
        end
    end

    // ------------------------------------------------------------------
    // Scaled distance: (|d| << 16) / sigma, one quotient bit per stage.
    // The top bit only flags a quotient that is past the clamp anyway.
    // ------------------------------------------------------------------
    logic [42:0]          r_rem [2][DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo [2][DIV_STEPS];
    logic [22:0]          r_u   [2];
    logic [45:0]          r_sq  [2];

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        assign diff[ax] = {2'b00, r_coord[ax], 16'b0} - {{2{centre[ax][25]}}, centre[ax]};

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_dist[ax] <= diff[ax][27] ? 27'(-diff[ax]) : diff[ax][26:0];
            end
        end

        for (genvar st = 0; st < DIV_STEPS; st++) begin : g_div
            localparam int unsigned SH = DIV_STEPS - 1 - st;
            logic [42:0]          rem_in;
            logic [DIV_STEPS-1:0] quo_in;
            logic [46:0]          trial;
            logic                 ge;

            if (st == 0) begin : g_first
                assign rem_in = {r_dist[ax], 16'b0};
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[ax][st-1];
                assign quo_in = r_quo[ax][st-1];
            end

            assign trial = {23'b0, sig_eff[ax]} << SH;
            assign ge    = {4'b0, rem_in} >= trial;

            always_ff @(posedge i_clk) begin
                if (pipe_en) begin
                    r_rem[ax][st] <= ge ? (rem_in - trial[42:0]) : rem_in;
                    r_quo[ax][st] <= {quo_in[DIV_STEPS-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_u[ax]  <= (r_quo[ax][DIV_STEPS-1] > {1'b0, U_CLAMP}) ?
                            U_CLAMP : r_quo[ax][DIV_STEPS-1][22:0];
                r_sq[ax] <= {23'b0, r_u[ax]} * {23'b0, r_u[ax]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Exponent: t = (u_r^2 + u_c^2) / 2 in Q16, w = t * log2(e),
    // split into integer k and fraction f, y = f * ln2 in Q30.
    // ------------------------------------------------------------------
    logic [46:0] sq_sum;
    logic [29:0] r_t;
    logic [60:0] w_prod;
    logic [30:0] r_w;
    logic [45:0] y_prod;
    t_hctx       r_yctx;

    assign sq_sum = {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
    assign w_prod = {31'b0, r_t} * {30'b0, LOG2E_Q30};
    assign y_prod = {30'b0, r_w[15:0]} * {16'b0, LN2_Q30};

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_t         <= sq_sum[46:17];
            r_w         <= w_prod[60:30];
            r_yctx.y    <= y_prod[45:16];
            r_yctx.k    <= r_w[20:16];
            r_yctx.kbig <= |r_w[30:21];
        end
    end

    // ------------------------------------------------------------------
    // exp(-y) by the series p = 1 - y*p/n, n from 9 down to 1. Each step
    // is a product stage, a reciprocal stage and a correction stage.
    // ------------------------------------------------------------------
    logic [29:0] r_ha_v  [HORNER_STEPS];
    t_hctx       r_ha_c  [HORNER_STEPS];
    logic [29:0] r_hb_q0 [HORNER_STEPS];
    logic [29:0] r_hb_v  [HORNER_STEPS];
    t_hctx       r_hb_c  [HORNER_STEPS];
    logic [30:0] r_hc_p  [HORNER_STEPS];
    t_hctx       r_hc_c  [HORNER_STEPS];

    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
        localparam logic [32:0] RECIP = HORNER_RECIP[HORNER_STEPS-g];
        localparam logic [33:0] NV    = 34'(HORNER_STEPS - g);
        logic [30:0] p_in;
        t_hctx       c_in;
        logic [60:0] vp;
        logic [62:0] vm;
        logic [33:0] q0n;
        logic [33:0] rem;
        logic [29:0] q;

        if (g == 0) begin : g_first
            assign p_in = ONE_Q30;
            assign c_in = r_yctx;
        end else begin : g_next
            assign p_in = r_hc_p[g-1];
            assign c_in = r_hc_c[g-1];
        end

        assign vp  = {31'b0, c_in.y} * {30'b0, p_in};
        assign vm  = {33'b0, r_ha_v[g]} * {30'b0, RECIP};
        assign q0n = {4'b0, r_hb_q0[g]} * NV;
        assign rem = {4'b0, r_hb_v[g]} - q0n;
        assign q   = r_hb_q0[g] + ((rem >= NV) ? 30'd1 : 30'd0);

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_ha_v[g]  <= vp[59:30];
                r_ha_c[g]  <= c_in;
                r_hb_q0[g] <= vm[61:32];
                r_hb_v[g]  <= r_ha_v[g];
                r_hb_c[g]  <= r_ha_c[g];
                r_hc_p[g]  <= ONE_Q30 - {1'b0, q};
                r_hc_c[g]  <= r_hb_c[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // 2^-k shift, amplitude, background and saturation.
    // ------------------------------------------------------------------
    t_hctx       last_c;
    logic [30:0] r_e;
    logic [31:0] h_eff;
    logic [63:0] g_prod;
    logic [32:0] r_gauss;
    logic [34:0] sum;
    logic        sat_hi;
    logic        sat_lo;

    assign last_c = r_hc_c[HORNER_STEPS-1];
    assign h_eff  = (r_peak == '0) ? r_h_dflt : r_peak;
    assign g_prod = {32'b0, h_eff} * {33'b0, r_e};
    assign sum    = {2'b0, r_gauss} + {{3{r_offset[31]}}, r_offset};
    assign sat_hi = !sum[34] && (sum[33:31] != 3'b000);
    assign sat_lo = sum[34] && (sum[33:31] != 3'b111);

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_e     <= last_c.kbig ? '0 : (r_hc_p[HORNER_STEPS-1] >> last_c.k);
            r_gauss <= g_prod[62:30];
            r_out.pixel_value  <= sat_hi ? 32'sh7FFF_FFFF :
                                  sat_lo ? 32'sh8000_0000 : $signed(sum[31:0]);
            r_out.saturated    <= sat_hi || sat_lo;
            r_out.last_pixel   <= r_side[LAT-1].last_pixel;
            r_out.outside_grid <= r_side[LAT-1].outside_grid;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic out_at_rail;

    assign out_at_rail = (o_out_word.pixel_value == 32'sh7FFF_FFFF) ||
                         (o_out_word.pixel_value == 32'sh8000_0000);

    `G2D_ASSERT_NOW(a_sat_clamps, o_out_valid && o_out_word.saturated, out_at_rail)
    `G2D_ASSERT_NOW(a_last_inside, o_out_valid, !(o_out_word.last_pixel && o_out_word.outside_grid))
    `G2D_ASSERT_NEXT(a_sigma_wr_stalls, sig_wr, o_in_stall)
    `G2D_ASSERT_NEXT(a_out_drains, r_out_vld && !i_out_stall && !r_vld[LAT-1], !r_out_vld)

endmodule
